@@ src/gcss_pkg.sv @@
`default_nettype none

package gcss_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_VALUE   = 3'd0,
      OP_PUSH_FRAME   = 3'd1,
      OP_POP_FRAME    = 3'd2,
      OP_POP_VALUE    = 3'd3,
      OP_TAIL_RESTART = 3'd4,
      OP_TAIL_ARG     = 3'd5
   } gcss_op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_OVERFLOW  = 3'd1,
      STAT_NO_MARK   = 3'd2,
      STAT_MISMATCH  = 3'd3,
      STAT_UNDERFLOW = 3'd4
   } gcss_status_type;

   localparam logic [7:0] TAG_ALLOC  = 8'h41;
   localparam logic [7:0] TAG_FRAME  = 8'h46;
   localparam logic [7:0] TAG_RESULT = 8'h52;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      logic [31:0] function_ref;
      logic [7:0]  kind_tag;
      logic [9:0]  frame_slot;
   } gcss_req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [2:0]  status;
   } gcss_rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FIRST,
      S_SECOND,
      S_THIRD,
      S_EMIT
   } gcss_state_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_CLEAR,
      STEP_FIRST,
      STEP_SECOND,
      STEP_THIRD,
      STEP_EMIT
   } gcss_step_type;

   typedef struct packed {
      logic          capture;
      gcss_step_type step;
   } gcss_cmd_type;

   typedef struct packed {
      logic ends_first;
      logic pop_frame;
      logic clear_last;
      logic out_free;
   } gcss_sts_type;

endpackage

`default_nettype wire

@@ src/gcss_ctrl.sv @@
`default_nettype none

module gcss_ctrl import gcss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire gcss_sts_type sts,
   output gcss_cmd_type      cmd
);

   gcss_state_type state_ff;
   gcss_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            state_in = sts.ends_first ? S_EMIT : S_SECOND;
         end
         S_SECOND: begin
            state_in = sts.pop_frame ? S_THIRD : S_EMIT;
         end
         S_THIRD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.step    = STEP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.step = STEP_CLEAR;
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_FIRST: begin
            cmd.step = STEP_FIRST;
         end
         S_SECOND: begin
            cmd.step = STEP_SECOND;
         end
         S_THIRD: begin
            cmd.step = STEP_THIRD;
         end
         S_EMIT: begin
            cmd.step = STEP_EMIT;
         end
         default: begin
            cmd.step = STEP_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/gcss_datapath.sv @@
`default_nettype none

module gcss_datapath import gcss_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int WORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire gcss_req_type req_payload,
   input  wire gcss_cmd_type cmd,
   output gcss_sts_type      sts,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output gcss_rsp_type      rsp_payload
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = ADDR_BITS + 2;
   localparam int LINK_BITS = WORD_BITS + 1;
   localparam logic [CNT_BITS-1:0]  DEPTH_C     = CNT_BITS'(DEPTH);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR   = ADDR_BITS'(DEPTH - 1);
   localparam logic [31:0]          SLOT_LIMIT  = 32'(DEPTH);
   localparam logic [LINK_BITS-1:0] LINK_LIMIT  = LINK_BITS'(DEPTH);

   logic [WORD_BITS-1:0] word_mem [DEPTH];
   logic [7:0]           tag_mem  [DEPTH];

   gcss_req_type         req_ff, req_in;
   gcss_rsp_type         res_ff, res_in;
   gcss_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] top_ff, top_in;
   logic [ADDR_BITS-1:0] cf_ff, cf_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [WORD_BITS-1:0] link_ff, link_in;
   logic [7:0]           mark_ff, mark_in;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic [7:0]           rd_tag_ff;

   logic [ADDR_BITS-1:0] mem_addr;
   logic                 mem_we_word;
   logic                 mem_we_tag;
   logic [WORD_BITS-1:0] mem_wword;
   logic [7:0]           mem_wtag;

   logic                 fit_one, fit_two, fit_restart;
   logic                 slot_out, func_out, parent_ok;
   logic [ADDR_BITS-1:0] slot_addr;
   logic [WORD_BITS-1:0] value_w, func_w;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (mem_we_word) begin
         word_mem[mem_addr] <= mem_wword;
      end
      if (mem_we_tag) begin
         tag_mem[mem_addr] <= mem_wtag;
      end
      rd_word_ff <= word_mem[mem_addr];
      rd_tag_ff  <= tag_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         cf_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         cf_ff        <= cf_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      link_ff <= link_in;
      mark_ff <= mark_in;
   end

   assign fit_one     = (CNT_BITS'(top_ff) + CNT_BITS'(1)) < DEPTH_C;
   assign fit_two     = (CNT_BITS'(top_ff) + CNT_BITS'(2)) < DEPTH_C;
   assign fit_restart = (CNT_BITS'(cf_ff) + CNT_BITS'(2)) < DEPTH_C;
   assign slot_out    = 32'(req_ff.frame_slot) >= SLOT_LIMIT;
   assign func_out    = (32'(req_ff.frame_slot) + 32'd1) >= SLOT_LIMIT;
   assign parent_ok   = LINK_BITS'(link_ff) < LINK_LIMIT;
   assign slot_addr   = ADDR_BITS'(req_ff.frame_slot);
   assign value_w     = WORD_BITS'(req_ff.value);
   assign func_w      = WORD_BITS'(req_ff.function_ref);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mem_addr    = top_ff;
      mem_we_word = 1'b0;
      mem_we_tag  = 1'b0;
      mem_wword   = '0;
      mem_wtag    = '0;
      top_in      = top_ff;
      cf_in       = cf_ff;
      clr_in      = clr_ff;
      res_in      = res_ff;
      link_in     = link_ff;
      mark_in     = mark_ff;
      req_in      = req_ff;
      if (cmd.capture) begin
         req_in = req_payload;
      end
      unique case (cmd.step)
         STEP_CLEAR: begin
            mem_addr    = clr_ff;
            mem_we_word = 1'b1;
            mem_we_tag  = 1'b1;
            clr_in      = clr_ff + ADDR_BITS'(1);
         end
         STEP_FIRST: begin
            res_in.read_value = '0;
            res_in.status     = STAT_OK;
            unique case (req_ff.op)
               OP_PUSH_VALUE, OP_TAIL_ARG: begin
                  if (!fit_one) begin
                     res_in.status = STAT_OVERFLOW;
                  end else begin
                     mem_we_word = 1'b1;
                     mem_we_tag  = (req_ff.op == OP_PUSH_VALUE);
                     mem_wword   = value_w;
                     mem_wtag    = TAG_ALLOC;
                     top_in      = top_ff + ADDR_BITS'(1);
                  end
               end
               OP_PUSH_FRAME: begin
                  if (!fit_two) begin
                     res_in.status = STAT_OVERFLOW;
                  end else begin
                     mem_we_word       = 1'b1;
                     mem_we_tag        = 1'b1;
                     mem_wword         = WORD_BITS'(cf_ff);
                     mem_wtag          = TAG_FRAME;
                     res_in.read_value = 32'(top_ff);
                  end
               end
               OP_POP_FRAME: begin
                  mem_addr = slot_addr;
               end
               OP_POP_VALUE: begin
                  if (top_ff == '0) begin
                     res_in.status = STAT_UNDERFLOW;
                  end else begin
                     mem_addr = top_ff - ADDR_BITS'(1);
                  end
               end
               OP_TAIL_RESTART: begin
                  if (!fit_restart) begin
                     res_in.status = STAT_OVERFLOW;
                  end else begin
                     top_in = cf_ff + ADDR_BITS'(2);
                  end
               end
               default: begin
               end
            endcase
         end
         STEP_SECOND: begin
            unique case (req_ff.op)
               OP_PUSH_FRAME: begin
                  mem_addr    = top_ff + ADDR_BITS'(1);
                  mem_we_word = 1'b1;
                  mem_we_tag  = 1'b1;
                  mem_wword   = func_w;
                  mem_wtag    = req_ff.kind_tag;
                  cf_in       = top_ff;
                  top_in      = top_ff + ADDR_BITS'(2);
               end
               OP_POP_FRAME: begin
                  link_in  = rd_word_ff;
                  mark_in  = rd_tag_ff;
                  mem_addr = slot_addr + ADDR_BITS'(1);
               end
               OP_POP_VALUE: begin
                  res_in.read_value = 32'(rd_word_ff);
                  top_in            = top_ff - ADDR_BITS'(1);
               end
               default: begin
               end
            endcase
         end
         STEP_THIRD: begin
            if (slot_out || mark_ff != TAG_FRAME) begin
               res_in.status = STAT_NO_MARK;
            end else if (func_out || rd_word_ff != func_w) begin
               res_in.status = STAT_MISMATCH;
            end else begin
               mem_addr    = slot_addr;
               mem_we_word = 1'b1;
               mem_we_tag  = 1'b1;
               mem_wword   = value_w;
               mem_wtag    = TAG_RESULT;
               top_in      = slot_addr + ADDR_BITS'(1);
               cf_in       = parent_ok ? ADDR_BITS'(link_ff) : '0;
            end
         end
         STEP_EMIT, STEP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step == STEP_EMIT && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sts.out_free   = out_free;
      sts.clear_last = (clr_ff == LAST_ADDR);
      sts.pop_frame  = (req_ff.op == OP_POP_FRAME);
      unique case (req_ff.op)
         OP_PUSH_FRAME: sts.ends_first = !fit_two;
         OP_POP_FRAME:  sts.ends_first = 1'b0;
         OP_POP_VALUE:  sts.ends_first = (top_ff == '0);
         default:       sts.ends_first = 1'b1;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The top and the current frame always name a slot inside the store.
   a_top_in_range : assert property (@(posedge clock) disable iff (reset)
      CNT_BITS'(top_ff) < DEPTH_C)
      else $error("top index left the store");

   a_frame_in_range : assert property (@(posedge clock) disable iff (reset)
      CNT_BITS'(cf_ff) < DEPTH_C)
      else $error("current frame left the store");

   a_error_reads_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == STAT_OK || rsp_ff.read_value == '0))
      else $error("failed request returned a nonzero value");

endmodule

`default_nettype wire

@@ src/gc_shadow_stack_map.sv @@
// An accepted request runs the first step only (push value, tail ops, unused codes, overflow,
// underflow), the first and second (push frame, pop value) or first, second and third (any pop
// frame), then loads its result once the output register is free; one store access per cycle.
// A finished response waits in an output register while the next request is taken.
// Reset is synchronous; afterwards a clearing pass zeroes every slot of the store
// before the first request is accepted.
`default_nettype none

module gc_shadow_stack_map import gcss_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int WORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire gcss_req_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output gcss_rsp_type      rsp_payload
);

   gcss_cmd_type cmd;
   gcss_sts_type sts;

   gcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gcss_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ dv/tb_gc_shadow_stack_map.sv @@
`default_nettype none

module tb_gc_shadow_stack_map;
   timeunit 1ns;
   timeprecision 1ps;

   import gcss_pkg::*;

   localparam int DEPTH          = 1024;
   localparam int RANDOM_ITEMS   = 850;
   localparam int STALL_AT       = 200;
   localparam int STALL_CYCLES   = 400;
   localparam int DRAIN_AT       = 500;
   localparam int CALM_FROM      = 650;
   localparam int CALM_TO        = 800;
   localparam int UNWIND_TOP     = 256;
   localparam int WATCHDOG_LIMIT = 20000;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   gcss_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   gcss_rsp_type rsp_payload;

   // Index 0 tracks the stack while requests are generated, index 1 predicts responses.
   logic [31:0] stack_word [2][DEPTH];
   logic [7:0]  stack_tag  [2][DEPTH];
   int unsigned stack_top  [2];
   int unsigned frame_base [2];

   gcss_req_type pending_reqs  [$];
   gcss_rsp_type expected_rsps [$];

   int total_items;
   int req_count;
   int rsp_count;
   int fail_count;
   int quiet_cycles;
   int hold_left;
   bit stall_done;
   int status_seen [8];

   gc_shadow_stack_map #(
      .DEPTH     (DEPTH),
      .WORD_BITS (32)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic gcss_rsp_type run_stack_op(input int m, input gcss_req_type r);
      gcss_rsp_type res;
      int unsigned  t;
      int unsigned  slot;
      logic [31:0]  parent;
      res = '0;
      t = stack_top[m];
      slot = r.frame_slot;
      case (r.op)
         OP_PUSH_VALUE, OP_TAIL_ARG: begin
            if (t + 1 >= DEPTH) begin
               res.status = STAT_OVERFLOW;
            end else begin
               stack_word[m][t] = r.value;
               if (r.op == OP_PUSH_VALUE) stack_tag[m][t] = TAG_ALLOC;
               stack_top[m] = t + 1;
            end
         end
         OP_PUSH_FRAME: begin
            if (t + 2 >= DEPTH) begin
               res.status = STAT_OVERFLOW;
            end else begin
               stack_word[m][t] = frame_base[m];
               stack_tag[m][t] = TAG_FRAME;
               stack_word[m][t + 1] = r.function_ref;
               stack_tag[m][t + 1] = r.kind_tag;
               frame_base[m] = t;
               stack_top[m] = t + 2;
               res.read_value = t;
            end
         end
         OP_POP_FRAME: begin
            if (stack_tag[m][slot] != TAG_FRAME) begin
               res.status = STAT_NO_MARK;
            end else if (slot + 1 >= DEPTH || stack_word[m][slot + 1] != r.function_ref) begin
               res.status = STAT_MISMATCH;
            end else begin
               parent = stack_word[m][slot];
               stack_word[m][slot] = r.value;
               stack_tag[m][slot] = TAG_RESULT;
               stack_top[m] = slot + 1;
               frame_base[m] = (parent < DEPTH) ? parent : 0;
            end
         end
         OP_POP_VALUE: begin
            if (t == 0) begin
               res.status = STAT_UNDERFLOW;
            end else begin
               res.read_value = stack_word[m][t - 1];
               stack_top[m] = t - 1;
            end
         end
         OP_TAIL_RESTART: begin
            if (frame_base[m] + 2 >= DEPTH) res.status = STAT_OVERFLOW;
            else stack_top[m] = frame_base[m] + 2;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic queue_req(input logic [2:0] op, input logic [31:0] value,
                            input logic [31:0] fn, input logic [7:0] tag,
                            input logic [9:0] slot);
      gcss_req_type r;
      r.op = op;
      r.value = value;
      r.function_ref = fn;
      r.kind_tag = tag;
      r.frame_slot = slot;
      void'(run_stack_op(0, r));
      pending_reqs.push_back(r);
   endtask

   function automatic int pick_frame_mark();
      int marks [$];
      for (int i = 0; i < DEPTH; i++) begin
         if (stack_tag[0][i] == TAG_FRAME) marks.push_back(i);
      end
      if (marks.size() == 0) return -1;
      return marks[$urandom_range(marks.size() - 1)];
   endfunction

   task automatic queue_frame_pop();
      int          slot;
      logic [31:0] fn;
      if (stack_tag[0][frame_base[0]] == TAG_FRAME && $urandom_range(3) != 0)
         slot = frame_base[0];
      else
         slot = pick_frame_mark();
      if (slot < 0) slot = $urandom_range(DEPTH - 1);
      fn = (slot < DEPTH - 1) ? stack_word[0][slot + 1] : $urandom;
      if ($urandom_range(7) == 0) fn ^= 32'h1 << $urandom_range(31);
      queue_req(OP_POP_FRAME, $urandom, fn, $urandom, slot);
   endtask

   // Overwrites the parent link of a fresh frame through a tail argument, then pops it,
   // so the current frame can be steered to any slot; a link past the end of the store sends it to 0.
   task automatic queue_forged_link(input logic [31:0] link);
      int unsigned mark;
      logic [31:0] fn;
      while (stack_top[0] > DEPTH - 3) queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      mark = stack_top[0];
      fn = $urandom;
      queue_req(OP_PUSH_FRAME, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_TAIL_ARG, link, $urandom, $urandom, $urandom);
      queue_req(OP_PUSH_VALUE, fn, $urandom, $urandom, $urandom);
      queue_req(OP_POP_FRAME, $urandom, fn, $urandom, mark);
      if ($urandom_range(1) == 0) queue_req(OP_TAIL_RESTART, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int          pick;
      logic [31:0] link;
      for (int m = 0; m < 2; m++) begin
         for (int i = 0; i < DEPTH; i++) begin
            stack_word[m][i] = '0;
            stack_tag[m][i] = '0;
         end
         stack_top[m] = 0;
         frame_base[m] = 0;
      end

      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_POP_FRAME, '1, '1, '1, 10'd0);
      queue_req(OP_POP_FRAME, '0, '0, '0, 10'h3FF);
      queue_req(OP_PUSH_VALUE, 32'hFFFF_FFFF, '0, '0, '0);
      queue_req(OP_PUSH_VALUE, 32'h0, '1, '1, '1);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_SPARE_6, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_SPARE_7, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_PUSH_FRAME, $urandom, 32'hFFFF_FFFF, 8'hFF, $urandom);
      queue_req(OP_POP_FRAME, $urandom, 32'h0, $urandom, 10'd1);
      queue_req(OP_PUSH_FRAME, $urandom, 32'h0, 8'h00, $urandom);
      queue_req(OP_TAIL_RESTART, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_TAIL_ARG, 32'h1234_5678, $urandom, $urandom, $urandom);
      queue_req(OP_POP_FRAME, 32'hFFFF_FFFF, 32'h0, $urandom, 10'd3);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_TAIL_ARG, DEPTH - 3, $urandom, $urandom, $urandom);
      queue_req(OP_PUSH_VALUE, 32'hCAFE_F00D, $urandom, $urandom, $urandom);
      queue_req(OP_POP_FRAME, 32'hA5A5_A5A5, 32'hCAFE_F00D, $urandom, 10'd1);
      queue_req(OP_TAIL_RESTART, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_PUSH_VALUE, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_PUSH_FRAME, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_TAIL_ARG, $urandom, $urandom, $urandom, $urandom);
      queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);

      total_items = pending_reqs.size() + RANDOM_ITEMS;
      while (pending_reqs.size() < total_items) begin
         pick = $urandom_range(99);
         if (stack_top[0] >= UNWIND_TOP && pick < 45) pick = 60;
         if (pick < 30) begin
            queue_req(OP_PUSH_VALUE, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 45) begin
            queue_req(OP_PUSH_FRAME, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 60) begin
            queue_req(OP_POP_VALUE, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 75) begin
            queue_frame_pop();
         end else if (pick < 85) begin
            queue_req(OP_TAIL_RESTART, $urandom, $urandom, $urandom, $urandom);
            repeat ($urandom_range(4))
               queue_req(OP_TAIL_ARG, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 90) begin
            case ($urandom_range(2))
               0: link = DEPTH + $urandom_range(32'hFFFF_FFFF - DEPTH);
               1: link = DEPTH - 2 + $urandom_range(1);
               default: link = $urandom_range(stack_top[0]);
            endcase
            queue_forged_link(link);
         end else begin
            queue_req($urandom_range(7), $urandom, $urandom, $urandom, $urandom);
         end
      end
      total_items = pending_reqs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (rsp_count != total_items) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d requests through the stack map: value and frame pushes and pops,",
               req_count);
      $display("tail calls, forged parent links; statuses ok/ovf/mark/func/empty: %0d/%0d/%0d/%0d/%0d",
               status_seen[STAT_OK], status_seen[STAT_OVERFLOW], status_seen[STAT_NO_MARK],
               status_seen[STAT_MISMATCH], status_seen[STAT_UNDERFLOW]);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_rsps.push_back(run_stack_op(1, req_payload));
            req_count++;
         end
         if (pending_reqs.size() != 0 && !(req_count == DRAIN_AT && rsp_count != req_count)
             && ((req_count >= CALM_FROM && req_count < CALM_TO) || $urandom_range(99) >= 8)) begin
            req_valid <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_check
      gcss_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_payload);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               status_seen[want.status]++;
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %h, got %h", want.read_value,
                         rsp_payload.read_value);
                  fail_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_count == STALL_AT && !stall_done) begin
            stall_done = 1'b1;
            hold_left = STALL_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (rsp_count >= CALM_FROM && rsp_count < CALM_TO)
                         || $urandom_range(99) >= 8;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

`default_nettype wire

@@ sim.f @@
src/gcss_pkg.sv
src/gcss_ctrl.sv
src/gcss_datapath.sv
src/gc_shadow_stack_map.sv
dv/tb_gc_shadow_stack_map.sv
